// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level scanner unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define WBPS_ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define WBPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wbps_pkg.sv =====
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int ADDR_W      = 64;
    localparam int COUNT_W     = 32;
    localparam int LEN_W       = 5;
    localparam int SEEN_MAX    = 16;
    localparam int PAT_BYTES   = 16;
    localparam int CARE_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW  = 3'd0,
        REG_PAT_HIGH = 3'd1,
        REG_CARE     = 3'd2,
        REG_LEN      = 3'd3,
        REG_MAX      = 3'd4
    } cfg_reg_t;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic              cand;
        logic              fresh;
        logic [ADDR_W-1:0] addr;
    } scan_entry_t;

endpackage

// ===== hw/rtl/wbps_front.sv =====
// Front end: window shift register, address tracking and parallel pattern compare.
module wbps_front
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_data_byte,
    input  logic                     s_first_byte,
    input  logic [ADDR_W-1:0]        s_base_address,
    input  logic                     s_new_search,
    input  logic [8*PAT_BYTES-1:0]   pattern,
    input  logic [CARE_W-1:0]        care_mask,
    input  logic [LEN_W-1:0]         pattern_len,
    input  logic                     q_ready,
    output logic                     q_push,
    output scan_entry_t              q_entry
);

    logic [7:0]        window_reg [MAX_PATTERN];
    logic [7:0]        window_next [MAX_PATTERN];
    logic [7:0]        win [MAX_PATTERN];
    logic [LEN_W-1:0]  bytes_seen_reg, bytes_seen_next;
    logic [LEN_W-1:0]  seen;
    logic [ADDR_W-1:0] cur_addr_reg, cur_addr_next;
    logic [ADDR_W-1:0] cur_addr;
    logic              accept;
    logic              len_ok;
    logic              mismatch;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cur_addr = s_first_byte ? s_base_address : cur_addr_reg;
        seen     = s_first_byte ? '0 : bytes_seen_reg;
        bytes_seen_next = (seen < LEN_W'(SEEN_MAX)) ? seen + LEN_W'(1) : seen;
        cur_addr_next   = cur_addr + ADDR_W'(1);

        // win[0] is the newest byte, win[a] the byte a steps earlier
        win[0] = s_data_byte;
        for (int a = 1; a < MAX_PATTERN; a++) begin
            win[a] = s_first_byte ? 8'h00 : window_reg[a-1];
        end
        for (int a = 0; a < MAX_PATTERN; a++) begin
            window_next[a] = win[a];
        end

        len_ok = (pattern_len != '0) && (pattern_len <= LEN_W'(MAX_PATTERN)) &&
                 (bytes_seen_next >= pattern_len);

        // pattern byte i lines up with window byte len-1-i
        mismatch = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            for (int a = 0; a < MAX_PATTERN; a++) begin
                if (care_mask[i] && (LEN_W'(i) < pattern_len) &&
                    (LEN_W'(a + i + 1) == pattern_len) &&
                    (win[a] != pattern[8*i +: 8])) begin
                    mismatch = 1'b1;
                end
            end
        end

        q_entry.cand  = len_ok && !mismatch;
        q_entry.fresh = s_new_search;
        q_entry.addr  = cur_addr - ADDR_W'(pattern_len) + ADDR_W'(1);
        // drop items that neither match nor clear the count
        q_push        = accept && (q_entry.cand || q_entry.fresh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
            cur_addr_reg   <= '0;
            for (int a = 0; a < MAX_PATTERN; a++) begin
                window_reg[a] <= 8'h00;
            end
        end else if (accept) begin
            bytes_seen_reg <= bytes_seen_next;
            cur_addr_reg   <= cur_addr_next;
            for (int a = 0; a < MAX_PATTERN; a++) begin
                window_reg[a] <= window_next[a];
            end
        end
    end

endmodule

// ===== hw/rtl/wbps_queue.sv =====
// Short FIFO of classified items between the front and the back.
module wbps_queue
    import wbps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  scan_entry_t push_entry,
    output logic        not_full,
    input  logic        pop,
    output logic        head_valid,
    output scan_entry_t head_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    scan_entry_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign not_full   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/wbps_back.sv =====
// Back end: match counting, result limit and the output register.
module wbps_back
    import wbps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  scan_entry_t        q_entry,
    output logic               q_pop,
    input  logic [COUNT_W-1:0] max_results,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ADDR_W-1:0]  m_match_address,
    output logic [COUNT_W-1:0] m_match_number,
    output logic               m_limit_reached
);

    logic               m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COUNT_W-1:0] number_reg, number_next;
    logic               limit_reg;
    logic [COUNT_W-1:0] found_reg, found_next;
    logic [COUNT_W-1:0] base_count;
    logic               emit;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && out_free;

    always_comb begin
        base_count   = q_entry.fresh ? '0 : found_reg;
        emit         = q_entry.cand && (base_count < max_results);
        number_next  = base_count + COUNT_W'(1);
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            found_next = emit ? number_next : base_count;
        end
        if (out_free) begin
            m_valid_next = q_pop && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            found_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
        end
    end

    // hold the payload until the result is taken
    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            addr_reg   <= q_entry.addr;
            number_reg <= number_next;
            limit_reg  <= (number_next == max_results);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_match_address = addr_reg;
    assign m_match_number  = number_reg;
    assign m_limit_reached = limit_reg;

endmodule

// ===== hw/rtl/wildcard_byte_pattern_scanner_unit.sv =====
// Each match is registered in the queue and then in the output register before m_valid rises.
// Throughput: one byte per cycle unless the queue is full, set by the combinational window compare
// in the front end; a four-item queue and one output register let either side stall on its own.
// Reset (aresetn low, synchronous): window, byte count, address and match count cleared,
// pattern registers zero, max_results all ones.
module wildcard_byte_pattern_scanner_unit
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_first_byte,
    input  logic [ADDR_W-1:0]     s_base_address,
    input  logic                  s_new_search,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDR_W-1:0]     m_match_address,
    output logic [COUNT_W-1:0]    m_match_number,
    output logic                  m_limit_reached
);

`include "assert_macros.svh"

    logic [63:0]        pat_low_reg;
    logic [63:0]        pat_high_reg;
    logic [CARE_W-1:0]  care_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [COUNT_W-1:0] max_reg;

    logic        q_push;
    logic        q_not_full;
    logic        q_pop;
    logic        q_valid;
    scan_entry_t push_entry;
    scan_entry_t head_entry;

    logic        chk_nonzero;
    logic        chk_in_limit;
    logic        chk_flag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            len_reg      <= '0;
            max_reg      <= '1;
        end else if (cfg_write_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_PAT_LOW:  pat_low_reg  <= cfg_data;
                REG_PAT_HIGH: pat_high_reg <= cfg_data;
                REG_CARE:     care_reg     <= cfg_data[CARE_W-1:0];
                REG_LEN:      len_reg      <= cfg_data[LEN_W-1:0];
                REG_MAX:      max_reg      <= cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wbps_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_first_byte  (s_first_byte),
        .s_base_address(s_base_address),
        .s_new_search  (s_new_search),
        .pattern       ({pat_high_reg, pat_low_reg}),
        .care_mask     (care_reg),
        .pattern_len   (len_reg),
        .q_ready       (q_not_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    wbps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(push_entry),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_entry(head_entry)
    );

    wbps_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_entry        (head_entry),
        .q_pop          (q_pop),
        .max_results    (max_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_address(m_match_address),
        .m_match_number (m_match_number),
        .m_limit_reached(m_limit_reached)
    );

    assign chk_nonzero  = !m_valid || (m_match_number != '0);
    assign chk_in_limit = !m_valid || (m_match_number <= max_reg);
    assign chk_flag     = !(m_valid && m_limit_reached) || (m_match_number == max_reg);

    `WBPS_ASSERT_ALWAYS(a_number_nonzero, aclk, aresetn, chk_nonzero, "match number zero")
    `WBPS_ASSERT_ALWAYS(a_number_in_limit, aclk, aresetn, chk_in_limit, "number beyond limit")
    `WBPS_ASSERT_ALWAYS(a_limit_flag, aclk, aresetn, chk_flag, "limit flag without limit count")
    `WBPS_ASSERT_NEXT(a_push_lands, aclk, aresetn, q_push, q_valid, "queued item not visible")

endmodule

// ===== verif/tb_wildcard_byte_pattern_scanner_unit.sv =====
// Testbench for the wildcard byte pattern scanner: directed cases, then random buffer scans.
module tb_wildcard_byte_pattern_scanner_unit
    import wbps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS     = 1250;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 12;
    localparam int IDLE_GUARD       = 20000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [63:0] ALL_ONES_32 = 64'hFFFF_FFFF;

    typedef struct {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] number;
        logic               limit;
    } match_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_data_byte;
    logic                  s_first_byte;
    logic [ADDR_W-1:0]     s_base_address;
    logic                  s_new_search;
    logic                  m_valid;
    logic                  m_ready;
    logic [ADDR_W-1:0]     m_match_address;
    logic [COUNT_W-1:0]    m_match_number;
    logic                  m_limit_reached;

    // Predictor configuration and scan state
    logic [63:0]        pattern_lo      = '0;
    logic [63:0]        pattern_hi      = '0;
    logic [CARE_W-1:0]  care_bits       = '0;
    logic [LEN_W-1:0]   pattern_len_cfg = '0;
    logic [COUNT_W-1:0] max_matches     = '1;
    logic [7:0]         prev_bytes [0:PAT_BYTES-2] = '{default: 8'h00};
    logic [LEN_W-1:0]   buf_seen    = '0;
    logic [ADDR_W-1:0]  byte_addr   = '0;
    logic [COUNT_W-1:0] match_total = '0;

    match_t pending_matches [$];
    int     mismatch_count = 0;
    int     burst_left     = 0;
    bit     gaps_enabled   = 1'b1;
    logic   long_hold_req  = 1'b0;

    wildcard_byte_pattern_scanner_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_first_byte    (s_first_byte),
        .s_base_address  (s_base_address),
        .s_new_search    (s_new_search),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match_address (m_match_address),
        .m_match_number  (m_match_number),
        .m_limit_reached (m_limit_reached)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pattern_byte(input int k);
        logic [127:0] both;
        both = {pattern_hi, pattern_lo};
        return both[8*k +: 8];
    endfunction

    task automatic predict_match(input logic [7:0] b, input logic first,
                                 input logic [63:0] base, input logic fresh);
        logic [7:0] win [0:PAT_BYTES-1];
        logic       hit;
        int         len;
        match_t     m;
        len = int'(pattern_len_cfg);
        if (fresh)
            match_total = '0;
        if (first) begin
            foreach (prev_bytes[i]) prev_bytes[i] = 8'h00;
            buf_seen  = '0;
            byte_addr = base;
        end
        // win[0] is the newest byte
        win[0] = b;
        for (int i = 1; i < PAT_BYTES; i++)
            win[i] = prev_bytes[i-1];
        if (buf_seen < SEEN_MAX)
            buf_seen++;
        hit = (len >= 1) && (len <= PAT_BYTES) && (int'(buf_seen) >= len) &&
              (match_total < max_matches);
        for (int i = 0; i < PAT_BYTES; i++) begin
            if (hit && i < len && care_bits[i] && win[len-1-i] !== pattern_byte(i))
                hit = 1'b0;
        end
        if (hit) begin
            match_total++;
            m.addr   = byte_addr - 64'(len - 1);
            m.number = match_total;
            m.limit  = (match_total == max_matches);
            pending_matches = {pending_matches, m};
        end
        for (int i = 0; i < PAT_BYTES - 1; i++)
            prev_bytes[i] = win[i];
        byte_addr++;
    endtask

    // Predict on every accepted byte, check every accepted match
    always @(posedge aclk) begin
        match_t got;
        match_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_match(s_data_byte, s_first_byte, s_base_address, s_new_search);
            if (m_valid && m_ready) begin
                got = '{m_match_address, m_match_number, m_limit_reached};
                if (pending_matches.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected match: addr %h number %0d limit %b",
                                 got.addr, got.number, got.limit);
                end else begin
                    want = pending_matches.pop_front();
                    if (got.addr !== want.addr || got.number !== want.number ||
                        got.limit !== want.limit) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"match mismatch: expected addr %h number %0d limit %b,",
                                      " got addr %h number %0d limit %b"},
                                     want.addr, want.number, want.limit,
                                     got.addr, got.number, got.limit);
                    end
                end
            end
        end
    end

    // Receiver: switches among four random stall patterns; long hold on request
    initial begin
        rx_mode_t mode;
        int       mode_left;
        m_ready   = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req <= 1'b0;
                m_ready       <= 1'b0;
                for (int n = 0; n < LONG_HOLD_CYCLES; n++)
                    @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 250);
            end
            mode_left--;
            case (mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= (mode_left % 5) >= 2;
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first,
                             input logic [63:0] base, input logic fresh);
        int gap;
        if (gaps_enabled && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data_byte    <= b;
        s_first_byte   <= first;
        s_base_address <= base;
        s_new_search   <= fresh;
        s_valid        <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid and wait for every expected match plus the pipeline tail
    task automatic wait_idle();
        int guard;
        s_valid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (pending_matches.size() != 0 && guard < IDLE_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge aclk);
        cfg_write_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_PAT_LOW:  pattern_lo      = value;
            REG_PAT_HIGH: pattern_hi      = value;
            REG_CARE:     care_bits       = value[CARE_W-1:0];
            REG_LEN:      pattern_len_cfg = value[LEN_W-1:0];
            REG_MAX:      max_matches     = value[COUNT_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] care, input logic [63:0] len,
                              input logic [63:0] limit);
        wait_idle();
        write_reg(REG_PAT_LOW, lo);
        write_reg(REG_PAT_HIGH, hi);
        write_reg(REG_CARE, care);
        write_reg(REG_LEN, len);
        write_reg(REG_MAX, limit);
    endtask

    // One buffer: planted copies of the pattern mixed with noise
    task automatic send_buffer(input int nbytes);
        logic [63:0] base;
        logic [7:0]  b;
        logic        first;
        int          plant;
        int          plant_len;
        base = ($urandom_range(0, 7) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 20)
                                           : rand64();
        first = ($urandom_range(0, 9) != 0);
        plant_len = (pattern_len_cfg >= 1 && pattern_len_cfg <= PAT_BYTES) ?
                    int'(pattern_len_cfg) : $urandom_range(1, PAT_BYTES);
        plant = -1;
        for (int k = 0; k < nbytes; k++) begin
            if (plant < 0 && $urandom_range(0, 2) == 0)
                plant = 0;
            if (plant >= 0) begin
                b = pattern_byte(plant);
                if (!care_bits[plant] || $urandom_range(0, 15) == 0)
                    b = 8'($urandom);
                plant++;
                if (plant >= plant_len)
                    plant = -1;
            end else if ($urandom_range(0, 1) == 0) begin
                b = pattern_byte($urandom_range(0, PAT_BYTES - 1));
            end else begin
                b = 8'($urandom);
            end
            send_byte(b, first && k == 0, (k == 0) ? base : rand64(),
                      (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0));
        end
    endtask

    // Addresses count from zero when no buffer start has been seen
    task automatic test_startup_address();
        set_config(64'h0, 64'h0, 64'h0, 64'd1, ALL_ONES_32);
        send_byte(8'h00, 1'b0, rand64(), 1'b0);
        send_byte(8'hFF, 1'b0, rand64(), 1'b0);
    endtask

    // Full sixteen-byte window across the top of the address space
    task automatic test_full_window_wrap();
        logic [63:0] base;
        set_config(64'hFF00_5A3C_C3A5_01FE, 64'h00FF_1234_8001_7F80, 64'hFFFF, 64'd16,
                   ALL_ONES_32);
        base = 64'hFFFF_FFFF_FFFF_FFFB;
        for (int k = 0; k < PAT_BYTES; k++)
            send_byte(pattern_byte(k), k == 0, base, k == 0);
    endtask

    // Care bits above the length and wildcard positions are ignored
    task automatic test_care_past_length();
        logic [63:0] base;
        set_config(64'h0000_0000_0000_3CA5, 64'h0, 64'hFFF1, 64'd2, ALL_ONES_32);
        base = rand64();
        send_byte(8'hA5, 1'b1, base, 1'b1);
        send_byte(8'h77, 1'b0, base, 1'b0);
        send_byte(8'hA5, 1'b0, base, 1'b0);
        send_byte(8'h00, 1'b0, base, 1'b0);
    endtask

    // Count stops at the limit until a new search; a zero limit never reports
    task automatic test_match_limit();
        set_config(64'h0, 64'h0, 64'h0, 64'd1, 64'd2);
        send_byte(8'h11, 1'b1, 64'h1000, 1'b1);
        send_byte(8'h22, 1'b0, 64'h0, 1'b0);
        send_byte(8'h33, 1'b0, 64'h0, 1'b0);
        send_byte(8'h44, 1'b0, 64'h0, 1'b1);
        set_config(64'h0, 64'h0, 64'h0, 64'd1, 64'd0);
        send_byte(8'h55, 1'b1, 64'h2000, 1'b1);
    endtask

    // Lengths of zero and beyond the window never match
    task automatic test_disabled_lengths();
        set_config(64'h0, 64'h0, 64'h0, 64'd0, ALL_ONES_32);
        send_byte(8'h5A, 1'b1, 64'h0, 1'b1);
        wait_idle();
        write_reg(REG_LEN, 64'd17);
        send_byte(8'hA5, 1'b0, 64'h0, 1'b0);
        wait_idle();
        write_reg(REG_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h3C, 1'b0, 64'h0, 1'b0);
    endtask

    // Hold the receiver off while bytes keep coming, so the block backs up
    task automatic test_output_backpressure();
        set_config(64'h0, 64'h0, 64'h0, 64'd1, ALL_ONES_32);
        gaps_enabled = 1'b0;
        long_hold_req <= 1'b1;
        for (int k = 0; k < 60; k++)
            send_byte(8'($urandom), k == 0, 64'h8000_0000_0000_0000, k == 0);
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_scan();
        int          sent;
        int          target;
        int          n;
        logic [63:0] care_word;
        logic [63:0] len_word;
        logic [63:0] limit_word;
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
            case (phase)
                0: set_config(64'h0, 64'h0, 64'hFFFF, 64'd16, ALL_ONES_32);
                1: set_config('1, '1, 64'h0, 64'd16, ALL_ONES_32);
                2: set_config(rand64(), rand64(), 64'hFFFF, 64'd1, 64'd1);
                default: begin
                    case ($urandom_range(0, 5))
                        0: care_word = 64'h0;
                        1: care_word = 64'hFFFF;
                        2: care_word = rand64();
                        default: care_word = 64'($urandom_range(0, 16'hFFFF));
                    endcase
                    case ($urandom_range(0, 9))
                        0: len_word = 64'($urandom_range(0, 31));
                        1: len_word = 64'd16;
                        default: len_word = 64'($urandom_range(1, 6));
                    endcase
                    // noise above the length field
                    if ($urandom_range(0, 5) == 0)
                        len_word = len_word | (rand64() << LEN_W);
                    if ($urandom_range(0, 9) < 6)
                        limit_word = ALL_ONES_32;
                    else
                        limit_word = 64'($urandom_range(0, 6));
                    if ($urandom_range(0, 5) == 0)
                        limit_word[63:COUNT_W] = $urandom;
                    set_config(rand64(), rand64(), care_word, len_word, limit_word);
                end
            endcase
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_UNUSED, rand64());
            gaps_enabled = (phase % 4 != 3);
            target = sent + $urandom_range(50, 120);
            while (sent < target) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)), rand64(),
                              1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                    : $urandom_range(1, 24);
                    send_buffer(n);
                    sent += n;
                end
            end
        end
        gaps_enabled = 1'b1;
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = REG_PAT_LOW;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_data_byte    = '0;
        s_first_byte   = 1'b0;
        s_base_address = '0;
        s_new_search   = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_startup_address();
        test_full_window_wrap();
        test_care_past_length();
        test_match_limit();
        test_disabled_lengths();
        test_output_backpressure();
        test_random_scan();

        wait_idle();
        foreach (pending_matches[i]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("missing match: addr %h number %0d limit %b",
                         pending_matches[i].addr, pending_matches[i].number,
                         pending_matches[i].limit);
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
